>>> hdl/ptt_pkg.sv
// shared types and constants of the periodic timer table
package ptt_pkg;

   // data path widths and the result limit
   localparam int DATA_W      = 32;
   localparam int SLOT_W      = 4;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = 5;

   // request actions
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_REM    = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_FIRED = 2'd0;
   localparam logic [1:0] KIND_NONE  = 2'd1;
   localparam logic [1:0] KIND_ADD   = 2'd2;
   localparam logic [1:0] KIND_REM   = 2'd3;

   // result status
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FAIL = 1'b1;

   // output of the shared subtract unit
   typedef struct packed {
      logic [DATA_W-1:0] diff;
      logic              zero;
   } alu_res_type;

   // per-field write enables of the slot store
   typedef struct packed {
      logic id;
      logic period;
      logic rem;
      logic tag;
   } mem_we_type;

endpackage

>>> hdl/ptt_alu.sv
// shared subtract and zero-detect unit used for countdown and id match
module ptt_alu (
   input  logic [ptt_pkg::DATA_W-1:0] op_a,
   input  logic [ptt_pkg::DATA_W-1:0] op_b,
   output ptt_pkg::alu_res_type       res
);

   // difference and its zero flag
   always_comb begin
      res.diff = op_a - op_b;
      res.zero = (res.diff == '0);
   end

endmodule

>>> hdl/ptt_slot_mem.sv
// per-slot store of timer id, period, remaining count and tag
module ptt_slot_mem #(
   parameter int SLOTS = 16
) (
   input  logic                               clock,
   input  ptt_pkg::mem_we_type                wr_en,
   input  logic [$clog2(SLOTS)-1:0]           wr_addr,
   input  logic [ptt_pkg::DATA_W-1:0]         wr_id,
   input  logic [ptt_pkg::DATA_W-1:0]         wr_period,
   input  logic [ptt_pkg::DATA_W-1:0]         wr_rem,
   input  logic [ptt_pkg::DATA_W-1:0]         wr_tag,
   input  logic [$clog2(SLOTS)-1:0]           rd_addr,
   output logic [ptt_pkg::DATA_W-1:0]         rd_id,
   output logic [ptt_pkg::DATA_W-1:0]         rd_period,
   output logic [ptt_pkg::DATA_W-1:0]         rd_rem,
   output logic [ptt_pkg::DATA_W-1:0]         rd_tag
);

   logic [ptt_pkg::DATA_W-1:0] id_mem     [SLOTS];
   logic [ptt_pkg::DATA_W-1:0] period_mem [SLOTS];
   logic [ptt_pkg::DATA_W-1:0] rem_mem    [SLOTS];
   logic [ptt_pkg::DATA_W-1:0] tag_mem    [SLOTS];

   logic [ptt_pkg::DATA_W-1:0] rd_id_ff;
   logic [ptt_pkg::DATA_W-1:0] rd_period_ff;
   logic [ptt_pkg::DATA_W-1:0] rd_rem_ff;
   logic [ptt_pkg::DATA_W-1:0] rd_tag_ff;

   // write port, one enable per field
   always_ff @(posedge clock) begin
      if (wr_en.id) begin
         id_mem[wr_addr] <= wr_id;
      end
      if (wr_en.period) begin
         period_mem[wr_addr] <= wr_period;
      end
      if (wr_en.rem) begin
         rem_mem[wr_addr] <= wr_rem;
      end
      if (wr_en.tag) begin
         tag_mem[wr_addr] <= wr_tag;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_id_ff     <= id_mem[rd_addr];
      rd_period_ff <= period_mem[rd_addr];
      rd_rem_ff    <= rem_mem[rd_addr];
      rd_tag_ff    <= tag_mem[rd_addr];
   end

   assign rd_id     = rd_id_ff;
   assign rd_period = rd_period_ff;
   assign rd_rem    = rd_rem_ff;
   assign rd_tag    = rd_tag_ff;

endmodule

>>> hdl/periodic_timer_table.sv
// top level of the periodic timer table: sequencer, valid bits and result register
//
// Usage: an item (tick, add or remove) is taken when start is high and busy
// is low. Results come out on the rsp_ ports at most one per cycle, each marked by
// rsp_strobe for a single cycle; rsp_last flags the final result of an item.
// The receiver cannot stall; every result must be taken in its strobe cycle.
// Item handling:
//   tick   - walks every slot through the slot store read port and the
//            shared subtractor, one slot per cycle; fired results appear
//            during the walk, the last one at the end
//   add    - zero interval or a free hint slot: answered with no busy
//            time; otherwise the valid bits are walked one per cycle
//            up to the last slot, stopping at the first free one
//   remove - walks the ids through the store and the subtractor,
//            stopping at the first match
// Reset (synchronous) clears all valid bits, the hint and the id counter;
// the slot store itself is not cleared, as the data of invalid slots is never used.
module periodic_timer_table #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_interval,
   input  logic [31:0] req_user_tag,
   input  logic [31:0] req_target_id,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic        rsp_status,
   output logic [31:0] rsp_timer_id,
   output logic [31:0] rsp_tag_out,
   output logic [3:0]  rsp_slot_index,
   output logic        rsp_last
);

   localparam int SIDX_W = $clog2(SLOTS);
   localparam int DW     = ptt_pkg::DATA_W;
   localparam int SW     = ptt_pkg::SLOT_W;
   localparam int CW     = ptt_pkg::CNT_W;
   localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(SLOTS - 1);
   localparam logic [CW-1:0]     MAX_CNT  = CW'(ptt_pkg::MAX_RESULTS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TICK  = 3'd1;
   localparam logic [2:0] S_FLUSH = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_REM   = 3'd4;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [SIDX_W-1:0] addr_ff, addr_in;
   logic              issue_ff, issue_in;
   logic              proc_vld_ff, proc_vld_in;
   logic [SIDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SIDX_W-1:0] hint_ff, hint_in;
   logic [DW-1:0]     idc_ff, idc_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              hold_vld_ff, hold_vld_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [DW-1:0]     interval_ff, interval_in;
   logic [DW-1:0]     tag_ff, tag_in;
   logic [DW-1:0]     target_ff, target_in;
   logic [DW-1:0]     hold_id_ff, hold_id_in;
   logic [DW-1:0]     hold_tag_ff, hold_tag_in;
   logic [SW-1:0]     hold_slot_ff, hold_slot_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [DW-1:0]     rsp_id_ff, rsp_id_in;
   logic [DW-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [SW-1:0]     rsp_slot_ff, rsp_slot_in;
   logic              rsp_last_ff, rsp_last_in;

   // store and subtractor connections
   ptt_pkg::mem_we_type  mem_we;
   logic [SIDX_W-1:0]    mem_wr_addr;
   logic [DW-1:0]        wr_id, wr_period, wr_rem, wr_tag;
   logic [DW-1:0]        rd_id, rd_period, rd_rem, rd_tag;
   logic [DW-1:0]        alu_a, alu_b;
   ptt_pkg::alu_res_type alu_res;

   ptt_slot_mem #(
      .SLOTS (SLOTS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_wr_addr),
      .wr_id     (wr_id),
      .wr_period (wr_period),
      .wr_rem    (wr_rem),
      .wr_tag    (wr_tag),
      .rd_addr   (addr_ff),
      .rd_id     (rd_id),
      .rd_period (rd_period),
      .rd_rem    (rd_rem),
      .rd_tag    (rd_tag)
   );

   ptt_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   // subtractor operands: id compare while removing, countdown otherwise
   always_comb begin
      if (state_ff == S_REM) begin
         alu_a = rd_id;
         alu_b = target_ff;
      end else begin
         alu_a = rd_rem;
         alu_b = DW'(1);
      end
   end

   // sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = addr_ff;
      valid_in      = valid_ff;
      hint_in       = hint_ff;
      idc_in        = idc_ff;
      cnt_in        = cnt_ff;
      hold_vld_in   = hold_vld_ff;
      rsp_strobe_in = 1'b0;
      interval_in   = interval_ff;
      tag_in        = tag_ff;
      target_in     = target_ff;
      hold_id_in    = hold_id_ff;
      hold_tag_in   = hold_tag_ff;
      hold_slot_in  = hold_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = '0;
      mem_wr_addr   = addr_ff;
      wr_id         = idc_ff;
      wr_period     = interval_ff;
      wr_rem        = interval_ff;
      wr_tag        = tag_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               interval_in = req_interval;
               tag_in      = req_user_tag;
               target_in   = req_target_id;
               addr_in     = '0;
               issue_in    = 1'b1;
               cnt_in      = '0;
               hold_vld_in = 1'b0;
               case (req_action)
                  ptt_pkg::ACT_TICK: begin
                     state_in = S_TICK;
                  end
                  ptt_pkg::ACT_ADD: begin
                     if (req_interval == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_kind_in   = ptt_pkg::KIND_ADD;
                        rsp_status_in = ptt_pkg::STAT_FAIL;
                        rsp_id_in     = '0;
                        rsp_tag_in    = '0;
                        rsp_slot_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else if (!valid_ff[hint_ff]) begin
                        // hint slot free: take it at once
                        mem_we            = '1;
                        mem_wr_addr       = hint_ff;
                        wr_period         = req_interval;
                        wr_rem            = req_interval;
                        wr_tag            = req_user_tag;
                        valid_in[hint_ff] = 1'b1;
                        hint_in           = (hint_ff == LAST_IDX) ? '0 : hint_ff + 1'b1;
                        idc_in            = idc_ff + 1'b1;
                        rsp_strobe_in     = 1'b1;
                        rsp_kind_in       = ptt_pkg::KIND_ADD;
                        rsp_status_in     = ptt_pkg::STAT_OK;
                        rsp_id_in         = idc_ff;
                        rsp_tag_in        = '0;
                        rsp_slot_in       = SW'(hint_ff);
                        rsp_last_in       = 1'b1;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  ptt_pkg::ACT_REM: begin
                     state_in = S_REM;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_TICK: begin
            // issue the next slot read
            proc_vld_in = issue_ff;
            proc_idx_in = addr_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            // count down the slot whose data is back
            if (proc_vld_ff && valid_ff[proc_idx_ff]) begin
               mem_we.rem  = 1'b1;
               mem_wr_addr = proc_idx_ff;
               wr_rem      = alu_res.zero ? rd_period : alu_res.diff;
               if (alu_res.zero && (cnt_ff < MAX_CNT)) begin
                  // send the held fired item, keep the new one back
                  if (hold_vld_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = ptt_pkg::KIND_FIRED;
                     rsp_status_in = ptt_pkg::STAT_OK;
                     rsp_id_in     = hold_id_ff;
                     rsp_tag_in    = hold_tag_ff;
                     rsp_slot_in   = hold_slot_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_vld_in  = 1'b1;
                  hold_id_in   = rd_id;
                  hold_tag_in  = rd_tag;
                  hold_slot_in = SW'(proc_idx_ff);
                  cnt_in       = cnt_ff + 1'b1;
               end
            end
            if (proc_vld_ff && (proc_idx_ff == LAST_IDX)) begin
               state_in = S_FLUSH;
            end
         end

         S_FLUSH: begin
            // final item of a tick
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = ptt_pkg::STAT_OK;
            if (hold_vld_ff) begin
               rsp_kind_in = ptt_pkg::KIND_FIRED;
               rsp_id_in   = hold_id_ff;
               rsp_tag_in  = hold_tag_ff;
               rsp_slot_in = hold_slot_ff;
            end else begin
               rsp_kind_in = ptt_pkg::KIND_NONE;
               rsp_id_in   = '0;
               rsp_tag_in  = '0;
               rsp_slot_in = '0;
            end
            hold_vld_in = 1'b0;
            state_in    = S_IDLE;
         end

         S_ADD: begin
            // lowest free slot search over the valid bits
            if (!valid_ff[addr_ff]) begin
               mem_we            = '1;
               mem_wr_addr       = addr_ff;
               valid_in[addr_ff] = 1'b1;
               hint_in           = addr_ff;
               idc_in            = idc_ff + 1'b1;
               rsp_strobe_in     = 1'b1;
               rsp_kind_in       = ptt_pkg::KIND_ADD;
               rsp_status_in     = ptt_pkg::STAT_OK;
               rsp_id_in         = idc_ff;
               rsp_tag_in        = '0;
               rsp_slot_in       = SW'(addr_ff);
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end else if (addr_ff == LAST_IDX) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = ptt_pkg::KIND_ADD;
               rsp_status_in = ptt_pkg::STAT_FAIL;
               rsp_id_in     = '0;
               rsp_tag_in    = '0;
               rsp_slot_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         S_REM: begin
            proc_vld_in = issue_ff;
            proc_idx_in = addr_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            // id match on the slot whose data is back
            if (proc_vld_ff && valid_ff[proc_idx_ff] && alu_res.zero) begin
               valid_in[proc_idx_ff] = 1'b0;
               hint_in               = proc_idx_ff;
               rsp_strobe_in         = 1'b1;
               rsp_kind_in           = ptt_pkg::KIND_REM;
               rsp_status_in         = ptt_pkg::STAT_OK;
               rsp_id_in             = target_ff;
               rsp_tag_in            = '0;
               rsp_slot_in           = SW'(proc_idx_ff);
               rsp_last_in           = 1'b1;
               issue_in              = 1'b0;
               proc_vld_in           = 1'b0;
               state_in              = S_IDLE;
            end else if (proc_vld_ff && (proc_idx_ff == LAST_IDX)) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = ptt_pkg::KIND_REM;
               rsp_status_in = ptt_pkg::STAT_FAIL;
               rsp_id_in     = target_ff;
               rsp_tag_in    = '0;
               rsp_slot_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         addr_ff       <= '0;
         issue_ff      <= 1'b0;
         proc_vld_ff   <= 1'b0;
         proc_idx_ff   <= '0;
         valid_ff      <= '0;
         hint_ff       <= '0;
         idc_ff        <= '0;
         cnt_ff        <= '0;
         hold_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_ff      <= issue_in;
         proc_vld_ff   <= proc_vld_in;
         proc_idx_ff   <= proc_idx_in;
         valid_ff      <= valid_in;
         hint_ff       <= hint_in;
         idc_ff        <= idc_in;
         cnt_ff        <= cnt_in;
         hold_vld_ff   <= hold_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      interval_ff   <= interval_in;
      tag_ff        <= tag_in;
      target_ff     <= target_in;
      hold_id_ff    <= hold_id_in;
      hold_tag_ff   <= hold_tag_in;
      hold_slot_ff  <= hold_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ports
   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_timer_id   = rsp_id_ff;
   assign rsp_tag_out    = rsp_tag_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> hdl/ptt_checker.sv
// port-level checks of the periodic timer table and their binding
module ptt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_action,
   input logic [31:0] req_interval,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_kind,
   input logic        rsp_status,
   input logic        rsp_last
);

   // reset leaves the block idle and quiet
   assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   // a zero-interval add is refused in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ptt_pkg::ACT_ADD && req_interval == '0
      |=> rsp_strobe && rsp_kind == ptt_pkg::KIND_ADD
          && rsp_status == ptt_pkg::STAT_FAIL && rsp_last)
      else $error("zero interval add not refused");

   // a tick item always walks the table
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ptt_pkg::ACT_TICK |=> busy)
      else $error("tick did not start a walk");

   // add and remove give a single item
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == ptt_pkg::KIND_ADD || rsp_kind == ptt_pkg::KIND_REM)
      |-> rsp_last)
      else $error("add or remove reply without last");

   // unknown action gives nothing and stays idle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ptt_pkg::ACT_UNUSED |=> !busy && !rsp_strobe)
      else $error("unknown action not ignored");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_action   (req_action),
   .req_interval (req_interval),
   .rsp_strobe   (rsp_strobe),
   .rsp_kind     (rsp_kind),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);

>>> tb/ptt_event_check.sv
// checker for the periodic timer table: predicts every result and compares it
`timescale 1ns / 100ps

module ptt_event_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_interval,
   input  logic [31:0] req_user_tag,
   input  logic [31:0] req_target_id,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_kind,
   input  logic        rsp_status,
   input  logic [31:0] rsp_timer_id,
   input  logic [31:0] rsp_tag_out,
   input  logic [3:0]  rsp_slot_index,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_cnt,
   output int          checked_cnt
);

   localparam int NUM_SLOTS  = 16;
   localparam int REPORT_MAX = 10;
   localparam int DATA_W     = ptt_pkg::DATA_W;
   localparam int SLOT_W     = ptt_pkg::SLOT_W;

   typedef struct packed {
      logic [1:0]        kind;
      logic              status;
      logic [DATA_W-1:0] timer_id;
      logic [DATA_W-1:0] tag;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } timer_rsp_type;

   // predicted table state
   logic              slot_live   [NUM_SLOTS];
   logic [DATA_W-1:0] slot_ident  [NUM_SLOTS];
   logic [DATA_W-1:0] slot_reload [NUM_SLOTS];
   logic [DATA_W-1:0] slot_count  [NUM_SLOTS];
   logic [DATA_W-1:0] slot_owner  [NUM_SLOTS];
   logic [SLOT_W-1:0] hint;
   logic [DATA_W-1:0] id_next;

   timer_rsp_type timer_events_q[$];
   int            n_reported;

   function automatic timer_rsp_type make_rsp(logic [1:0] kind, logic status,
                                              logic [DATA_W-1:0] tid,
                                              logic [DATA_W-1:0] tag,
                                              logic [SLOT_W-1:0] slot, logic last);
      timer_rsp_type r;
      r.kind     = kind;
      r.status   = status;
      r.timer_id = tid;
      r.tag      = tag;
      r.slot     = slot;
      r.last     = last;
      return r;
   endfunction

   // one tick: count down every live timer, reload and report the expired ones
   task automatic predict_tick();
      timer_rsp_type fired_q[$];
      timer_rsp_type r;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_live[i]) begin
            slot_count[i] = slot_count[i] - 1'b1;
            if (slot_count[i] == '0) begin
               slot_count[i] = slot_reload[i];
               if (fired_q.size() < ptt_pkg::MAX_RESULTS)
                  fired_q.push_back(make_rsp(ptt_pkg::KIND_FIRED, ptt_pkg::STAT_OK,
                                             slot_ident[i], slot_owner[i],
                                             SLOT_W'(i), 1'b0));
            end
         end
      end
      if (fired_q.size() == 0) begin
         timer_events_q.push_back(make_rsp(ptt_pkg::KIND_NONE, ptt_pkg::STAT_OK,
                                           '0, '0, '0, 1'b1));
      end else begin
         r = fired_q.pop_back();
         r.last = 1'b1;
         fired_q.push_back(r);
         foreach (fired_q[k]) timer_events_q.push_back(fired_q[k]);
      end
   endtask

   // add: hint slot first, else the lowest free slot
   task automatic predict_add(logic [DATA_W-1:0] ivl, logic [DATA_W-1:0] tag);
      int                free_slot;
      logic [SLOT_W-1:0] pick;
      free_slot = -1;
      if (ivl == '0) begin
         timer_events_q.push_back(make_rsp(ptt_pkg::KIND_ADD, ptt_pkg::STAT_FAIL,
                                           '0, '0, '0, 1'b1));
         return;
      end
      if (!slot_live[hint]) begin
         pick = hint;
         hint = hint + 1'b1;  // wraps at the table size
      end else begin
         for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (!slot_live[i]) free_slot = i;
         if (free_slot < 0) begin
            timer_events_q.push_back(make_rsp(ptt_pkg::KIND_ADD, ptt_pkg::STAT_FAIL,
                                              '0, '0, '0, 1'b1));
            return;
         end
         pick = SLOT_W'(free_slot);
         hint = pick;
      end
      slot_ident[pick]  = id_next;
      slot_reload[pick] = ivl;
      slot_count[pick]  = ivl;
      slot_owner[pick]  = tag;
      slot_live[pick]   = 1'b1;
      timer_events_q.push_back(make_rsp(ptt_pkg::KIND_ADD, ptt_pkg::STAT_OK,
                                        id_next, '0, pick, 1'b1));
      id_next = id_next + 1'b1;
   endtask

   // remove: lowest live slot holding the id
   task automatic predict_remove(logic [DATA_W-1:0] tgt);
      int hit;
      hit = -1;
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
         if (slot_live[i] && slot_ident[i] == tgt) hit = i;
      if (hit < 0) begin
         timer_events_q.push_back(make_rsp(ptt_pkg::KIND_REM, ptt_pkg::STAT_FAIL,
                                           tgt, '0, '0, 1'b1));
      end else begin
         hint = SLOT_W'(hit);
         slot_live[hit] = 1'b0;
         timer_events_q.push_back(make_rsp(ptt_pkg::KIND_REM, ptt_pkg::STAT_OK,
                                           tgt, '0, SLOT_W'(hit), 1'b1));
      end
   endtask

   task automatic compare_rsp(timer_rsp_type got);
      timer_rsp_type want;
      checked_cnt++;
      if (timer_events_q.size() == 0) begin
         fail_count++;
         if (n_reported < REPORT_MAX)
            $display("%0t check: unexpected result kind %0d id %h", $time,
                     got.kind, got.timer_id);
         n_reported++;
         return;
      end
      want = timer_events_q.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.timer_id !== want.timer_id || got.tag !== want.tag ||
          got.slot !== want.slot || got.last !== want.last) begin
         fail_count++;
         if (n_reported < REPORT_MAX) begin
            $display("%0t check: mismatch (expected / actual)", $time);
            $display("   kind %0d/%0d status %0d/%0d slot %0d/%0d last %0d/%0d",
                     want.kind, got.kind, want.status, got.status,
                     want.slot, got.slot, want.last, got.last);
            $display("   id %h/%h tag %h/%h", want.timer_id, got.timer_id,
                     want.tag, got.tag);
         end
         n_reported++;
      end
   endtask

   // results are compared before a new item is predicted in the same cycle
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 1'b0;
         hint        = '0;
         id_next     = '0;
         timer_events_q.delete();
         fail_count  = 0;
         checked_cnt = 0;
         n_reported  = 0;
      end else begin
         if (rsp_strobe)
            compare_rsp({rsp_kind, rsp_status, rsp_timer_id, rsp_tag_out,
                         rsp_slot_index, rsp_last});
         if (start && !busy) begin
            case (req_action)
               ptt_pkg::ACT_TICK: predict_tick();
               ptt_pkg::ACT_ADD:  predict_add(req_interval, req_user_tag);
               ptt_pkg::ACT_REM:  predict_remove(req_target_id);
               default: ;  // unused action, nothing happens
            endcase
         end
      end
      pending_cnt <= timer_events_q.size();
   end

endmodule

>>> tb/tb_periodic_timer_table.sv
// testbench top of the periodic timer table: stimulus, run limit and verdict
`timescale 1ns / 100ps

module tb_periodic_timer_table;

   localparam int RANDOM_ITEMS = 380;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic [1:0]  req_action    = ptt_pkg::ACT_TICK;
   logic [31:0] req_interval  = '0;
   logic [31:0] req_user_tag  = '0;
   logic [31:0] req_target_id = '0;

   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic        rsp_status;
   logic [31:0] rsp_timer_id;
   logic [31:0] rsp_tag_out;
   logic [3:0]  rsp_slot_index;
   logic        rsp_last;

   int fail_count;
   int pending_cnt;
   int checked_cnt;
   int cycle_cnt = 0;
   int n_tick    = 0;
   int n_add     = 0;
   int n_rem     = 0;
   int n_unused  = 0;

   logic [31:0] live_ids[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   periodic_timer_table #(.SLOTS(16)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_interval   (req_interval),
      .req_user_tag   (req_user_tag),
      .req_target_id  (req_target_id),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_timer_id   (rsp_timer_id),
      .rsp_tag_out    (rsp_tag_out),
      .rsp_slot_index (rsp_slot_index),
      .rsp_last       (rsp_last)
   );

   ptt_event_check u_event_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_interval   (req_interval),
      .req_user_tag   (req_user_tag),
      .req_target_id  (req_target_id),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_timer_id   (rsp_timer_id),
      .rsp_tag_out    (rsp_tag_out),
      .rsp_slot_index (rsp_slot_index),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending_cnt    (pending_cnt),
      .checked_cnt    (checked_cnt)
   );

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // keep the ids of live timers so that most removes hit one
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (rsp_kind == ptt_pkg::KIND_ADD && rsp_status == ptt_pkg::STAT_OK) begin
            live_ids.push_back(rsp_timer_id);
         end else if (rsp_kind == ptt_pkg::KIND_REM && rsp_status == ptt_pkg::STAT_OK) begin
            for (int k = 0; k < live_ids.size(); k++)
               if (live_ids[k] == rsp_timer_id) begin
                  live_ids.delete(k);
                  break;
               end
         end
      end
   end

   // present one item and hold it until it is taken
   task automatic send_item(logic [1:0] act, logic [31:0] ivl, logic [31:0] tag,
                            logic [31:0] tgt);
      req_action    <= act;
      req_interval  <= ivl;
      req_user_tag  <= tag;
      req_target_id <= tgt;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      case (act)
         ptt_pkg::ACT_TICK: n_tick++;
         ptt_pkg::ACT_ADD:  n_add++;
         ptt_pkg::ACT_REM:  n_rem++;
         default:           n_unused++;
      endcase
   endtask

   task automatic sender_gap(int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // lower start and wait until every predicted result has been seen
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_cnt != 0);
   endtask

   // mostly short periods so timers fire often, some full-range words
   function automatic logic [31:0] pick_interval();
      int r;
      r = $urandom_range(99);
      if (r < 6)  return '0;
      if (r < 70) return $urandom_range(6, 1);
      if (r < 90) return $urandom_range(40, 7);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_target();
      if (live_ids.size() > 0 && $urandom_range(99) < 80)
         return live_ids[$urandom_range(live_ids.size() - 1)];
      if ($urandom_range(1)) return $urandom;
      return $urandom_range(60, 0);
   endfunction

   task automatic send_random(int idle_pct);
      int         sel;
      logic [1:0] act;
      sel = $urandom_range(99);
      if (sel < 36)      act = ptt_pkg::ACT_TICK;
      else if (sel < 70) act = ptt_pkg::ACT_ADD;
      else if (sel < 97) act = ptt_pkg::ACT_REM;
      else               act = ptt_pkg::ACT_UNUSED;
      sender_gap(idle_pct);
      send_item(act, pick_interval(), $urandom, pick_target());
   endtask

   initial begin
      int phase_idle[4];
      int goal;
      phase_idle = '{0, 77, 23, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items
      send_item(ptt_pkg::ACT_TICK, '0, '0, '0);               // tick on an empty table
      send_item(ptt_pkg::ACT_ADD, '0, 32'hFFFF_FFFF, '0);     // zero interval
      send_item(ptt_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);  // longest period
      send_item(ptt_pkg::ACT_ADD, 32'd1, '0, 32'hFFFF_FFFF);  // fires on every tick
      send_item(ptt_pkg::ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ptt_pkg::ACT_REM, '0, '0, 32'hFFFF_FFFF);     // id not found
      send_item(ptt_pkg::ACT_REM, '0, '0, 32'd0);  // frees slot 0, hint moves there
      for (int i = 0; i < 15; i++)                 // fill the table
         send_item(ptt_pkg::ACT_ADD, 32'd1, $urandom, $urandom);
      send_item(ptt_pkg::ACT_ADD, 32'd5, $urandom, '0);       // table full
      send_item(ptt_pkg::ACT_TICK, '0, '0, '0);               // every slot fires at once
      send_item(ptt_pkg::ACT_UNUSED, $urandom, $urandom, $urandom);  // ignored action

      // hold off until the directed results are all in
      wait_drained();

      // random items in phases of sender idling
      goal = n_tick + n_add + n_rem;
      foreach (phase_idle[p]) begin
         goal += RANDOM_ITEMS / 4;
         while (n_tick + n_add + n_rem < goal) send_random(phase_idle[p]);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d ticks, %0d adds, %0d removes, %0d ignored items",
               n_tick, n_add, n_rem, n_unused);
      $display("%0d results compared, %0d failures", checked_cnt, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
